>>> design/bc5nm_pkg.sv
// Package with shared types, constants and a helper function of the BC5 normal-map decoder.
package bc5nm_pkg;

    localparam int unsigned TEXELS      = 16;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned PAL_N       = 8;
    localparam int unsigned SQ_STAGES   = 4;
    localparam int unsigned SQ_REM_W    = 10;
    localparam logic [CH_W-1:0]  ALPHA_FULL  = 8'hFF;
    localparam logic [CH_W-1:0]  BLUE_FLAT   = 8'd127;
    localparam logic [CNT_W-1:0] LAST_TEXEL  = 4'd15;
    localparam logic [12:0]      RECIP_7     = 13'd4682;
    localparam logic [12:0]      RECIP_5     = 13'd6554;
    localparam int unsigned      RECIP_SHIFT = 15;
    localparam logic [15:0]      FULL_SQ     = 16'd65025;

    typedef struct packed {
        logic [CNT_W-1:0] num;
        logic             last;
    } t_tag;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [CH_W-1:0]     root;
    } t_rt;

    // One restoring step of the digit-by-digit square root.
    function automatic t_rt sq_step(input t_rt in, input logic [1:0] pair);
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W+1:0] diff;
        t_rt                 res;
        cur   = {in.rem, pair};
        trial = {2'b00, in.root, 2'b01};
        diff  = cur - trial;
        if (cur >= trial) begin
            res.rem  = diff[SQ_REM_W-1:0];
            res.root = {in.root[CH_W-2:0], 1'b1};
        end else begin
            res.rem  = cur[SQ_REM_W-1:0];
            res.root = {in.root[CH_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

>>> design/bc5nm_zrec.sv
// Pipelined reconstruction of the normal Z channel from the red and green channels.
module bc5nm_zrec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [bc5nm_pkg::CH_W-1:0]  i_red,
    input  logic [bc5nm_pkg::CH_W-1:0]  i_green,
    input  bc5nm_pkg::t_tag             i_tag,
    output logic                        o_valid,
    output logic [bc5nm_pkg::CH_W-1:0]  o_red,
    output logic [bc5nm_pkg::CH_W-1:0]  o_green,
    output logic [bc5nm_pkg::CH_W-1:0]  o_blue,
    output bc5nm_pkg::t_tag             o_tag
);

    logic signed [9:0]  u_s;
    logic signed [9:0]  v_s;
    logic signed [19:0] uu_s;
    logic signed [19:0] vv_s;

    logic                       r_z1_valid;
    logic [15:0]                r_z1_uu;
    logic [15:0]                r_z1_vv;
    logic [bc5nm_pkg::CH_W-1:0] r_z1_red;
    logic [bc5nm_pkg::CH_W-1:0] r_z1_green;
    bc5nm_pkg::t_tag            r_z1_tag;

    logic [17:0] s_full;
    logic        s_pos;

    logic                       r_z2_valid;
    logic [15:0]                r_z2_s;
    logic                       r_z2_pos;
    logic [bc5nm_pkg::CH_W-1:0] r_z2_red;
    logic [bc5nm_pkg::CH_W-1:0] r_z2_green;
    bc5nm_pkg::t_tag            r_z2_tag;

    logic                       r_sq_valid [bc5nm_pkg::SQ_STAGES];
    bc5nm_pkg::t_rt             r_sq_rt    [bc5nm_pkg::SQ_STAGES];
    logic [15:0]                r_sq_s     [bc5nm_pkg::SQ_STAGES];
    logic                       r_sq_pos   [bc5nm_pkg::SQ_STAGES];
    logic [bc5nm_pkg::CH_W-1:0] r_sq_red   [bc5nm_pkg::SQ_STAGES];
    logic [bc5nm_pkg::CH_W-1:0] r_sq_green [bc5nm_pkg::SQ_STAGES];
    bc5nm_pkg::t_tag            r_sq_tag   [bc5nm_pkg::SQ_STAGES];

    logic [bc5nm_pkg::CH_W:0]   blue_sum;

    assign u_s  = $signed({1'b0, i_red, 1'b0}) - 10'sd255;
    assign v_s  = $signed({1'b0, i_green, 1'b0}) - 10'sd255;
    assign uu_s = u_s * u_s;
    assign vv_s = v_s * v_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1_valid <= 1'b0;
        end else if (i_en) begin
            r_z1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1_uu    <= uu_s[15:0];
            r_z1_vv    <= vv_s[15:0];
            r_z1_red   <= i_red;
            r_z1_green <= i_green;
            r_z1_tag   <= i_tag;
        end
    end

    assign s_full = {2'b00, bc5nm_pkg::FULL_SQ} - {2'b00, r_z1_uu} - {2'b00, r_z1_vv};
    assign s_pos  = !s_full[17] && (s_full != 18'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z2_valid <= 1'b0;
        end else if (i_en) begin
            r_z2_valid <= r_z1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z2_s     <= s_pos ? s_full[15:0] : 16'd0;
            r_z2_pos   <= s_pos;
            r_z2_red   <= r_z1_red;
            r_z2_green <= r_z1_green;
            r_z2_tag   <= r_z1_tag;
        end
    end

    for (genvar k = 0; k < bc5nm_pkg::SQ_STAGES; k++) begin : g_sq
        logic                       in_valid;
        bc5nm_pkg::t_rt             in_rt;
        bc5nm_pkg::t_rt             mid_rt;
        bc5nm_pkg::t_rt             out_rt;
        logic [15:0]                in_s;
        logic                       in_pos;
        logic [bc5nm_pkg::CH_W-1:0] in_red;
        logic [bc5nm_pkg::CH_W-1:0] in_green;
        bc5nm_pkg::t_tag            in_tag;

        if (k == 0) begin : g_first
            assign in_valid = r_z2_valid;
            assign in_rt    = '0;
            assign in_s     = r_z2_s;
            assign in_pos   = r_z2_pos;
            assign in_red   = r_z2_red;
            assign in_green = r_z2_green;
            assign in_tag   = r_z2_tag;
        end else begin : g_next
            assign in_valid = r_sq_valid[k-1];
            assign in_rt    = r_sq_rt[k-1];
            assign in_s     = r_sq_s[k-1];
            assign in_pos   = r_sq_pos[k-1];
            assign in_red   = r_sq_red[k-1];
            assign in_green = r_sq_green[k-1];
            assign in_tag   = r_sq_tag[k-1];
        end

        assign mid_rt = bc5nm_pkg::sq_step(in_rt, in_s[2*(7-2*k) +: 2]);
        assign out_rt = bc5nm_pkg::sq_step(mid_rt, in_s[2*(6-2*k) +: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_sq_valid[k] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rt[k]    <= out_rt;
                r_sq_s[k]     <= in_s;
                r_sq_pos[k]   <= in_pos;
                r_sq_red[k]   <= in_red;
                r_sq_green[k] <= in_green;
                r_sq_tag[k]   <= in_tag;
            end
        end
    end

    assign blue_sum = {1'b0, r_sq_rt[bc5nm_pkg::SQ_STAGES-1].root} + 9'd255;

    assign o_valid = r_sq_valid[bc5nm_pkg::SQ_STAGES-1];
    assign o_red   = r_sq_red[bc5nm_pkg::SQ_STAGES-1];
    assign o_green = r_sq_green[bc5nm_pkg::SQ_STAGES-1];
    assign o_tag   = r_sq_tag[bc5nm_pkg::SQ_STAGES-1];
    assign o_blue  = r_sq_pos[bc5nm_pkg::SQ_STAGES-1] ? blue_sum[bc5nm_pkg::CH_W:1]
                                                      : bc5nm_pkg::BLUE_FLAT;

    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_z2_valid) |=> r_sq_valid[0])
        else $error("Z pipeline dropped a request between stages.");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && o_valid) |=> (o_valid && $stable(o_tag) && $stable(o_blue)))
        else $error("Z pipeline output changed while stalled.");

    a_flat_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_sq_pos[bc5nm_pkg::SQ_STAGES-1]) |-> (o_blue == bc5nm_pkg::BLUE_FLAT))
        else $error("Out-of-disc texel did not take the flat blue value.");

endmodule

>>> design/bc5_normal_map_block_decoder_unit.sv
// Top level of the BC5 normal-map block decoder: palette build, texel issue and output register.
// Between texel issue and the output register, each texel passes the Z reconstruction pipeline.
// Throughput: one texel per cycle while the output is not stalled, set by the texel issue counter.
// The texel pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and the texel counter; no data register is cleared.
module bc5_normal_map_block_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: red_endpoint_a, red_endpoint_b, red_indices,
    // green_endpoint_a, green_endpoint_b, green_indices.
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: texel_number, red, green, blue, alpha, then zero padding.
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int unsigned CW = bc5nm_pkg::CH_W;
    localparam int unsigned NW = 48;

    logic [CW-1:0] in_ra;
    logic [CW-1:0] in_rb;
    logic [NW-1:0] in_ridx;
    logic [CW-1:0] in_ga;
    logic [CW-1:0] in_gb;
    logic [NW-1:0] in_gidx;

    logic          en;
    logic          issue;
    logic          b2_take;
    logic          in_fire;

    logic          r_b1_valid;
    logic [CW-1:0] r_b1_ra;
    logic [CW-1:0] r_b1_rb;
    logic [CW-1:0] r_b1_ga;
    logic [CW-1:0] r_b1_gb;
    logic          r_b1_rmode7;
    logic          r_b1_gmode7;
    logic [10:0]   r_b1_rnum7 [6];
    logic [10:0]   r_b1_gnum7 [6];
    logic [10:0]   r_b1_rnum5 [4];
    logic [10:0]   r_b1_gnum5 [4];
    logic [NW-1:0] r_b1_ridx;
    logic [NW-1:0] r_b1_gidx;

    logic          r_b2_valid;
    logic [CW-1:0] r_pal_r [bc5nm_pkg::PAL_N];
    logic [CW-1:0] r_pal_g [bc5nm_pkg::PAL_N];
    logic [NW-1:0] r_b2_ridx;
    logic [NW-1:0] r_b2_gidx;
    logic [CW-1:0] n_pal_r [bc5nm_pkg::PAL_N];
    logic [CW-1:0] n_pal_g [bc5nm_pkg::PAL_N];

    logic [bc5nm_pkg::CNT_W-1:0] r_cnt;
    logic [bc5nm_pkg::IDX_W-1:0] sel_r;
    logic [bc5nm_pkg::IDX_W-1:0] sel_g;

    logic            r_t1_valid;
    logic [CW-1:0]   r_t1_red;
    logic [CW-1:0]   r_t1_green;
    bc5nm_pkg::t_tag r_t1_tag;
    bc5nm_pkg::t_tag n_t1_tag;

    logic            z_valid;
    logic [CW-1:0]   z_red;
    logic [CW-1:0]   z_green;
    logic [CW-1:0]   z_blue;
    bc5nm_pkg::t_tag z_tag;

    logic            r_out_valid;
    logic [CW-1:0]   r_out_red;
    logic [CW-1:0]   r_out_green;
    logic [CW-1:0]   r_out_blue;
    bc5nm_pkg::t_tag r_out_tag;

    assign in_ra   = s_axis_tdata[7:0];
    assign in_rb   = s_axis_tdata[15:8];
    assign in_ridx = s_axis_tdata[63:16];
    assign in_ga   = s_axis_tdata[71:64];
    assign in_gb   = s_axis_tdata[79:72];
    assign in_gidx = s_axis_tdata[127:80];

    assign en      = !r_out_valid || m_axis_tready;
    assign issue   = en && r_b2_valid;
    assign b2_take = !r_b2_valid || (issue && (r_cnt == bc5nm_pkg::LAST_TEXEL));
    assign s_axis_tready = !r_b1_valid || b2_take;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // First block stage: palette numerators for both interpolation modes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_b1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b1_ra     <= in_ra;
            r_b1_rb     <= in_rb;
            r_b1_ga     <= in_ga;
            r_b1_gb     <= in_gb;
            r_b1_rmode7 <= in_ra > in_rb;
            r_b1_gmode7 <= in_ga > in_gb;
            r_b1_ridx   <= in_ridx;
            r_b1_gidx   <= in_gidx;
            for (int i = 0; i < 6; i++) begin
                r_b1_rnum7[i] <= 11'(6 - i) * {3'b000, in_ra} + 11'(i + 1) * {3'b000, in_rb};
                r_b1_gnum7[i] <= 11'(6 - i) * {3'b000, in_ga} + 11'(i + 1) * {3'b000, in_gb};
            end
            for (int i = 0; i < 4; i++) begin
                r_b1_rnum5[i] <= 11'(4 - i) * {3'b000, in_ra} + 11'(i + 1) * {3'b000, in_rb};
                r_b1_gnum5[i] <= 11'(4 - i) * {3'b000, in_ga} + 11'(i + 1) * {3'b000, in_gb};
            end
        end
    end

    // Second block stage: division by reciprocal multiplication and palette selection.
    always_comb begin
        logic [23:0] pr7;
        logic [23:0] pg7;
        logic [22:0] pr5;
        logic [22:0] pg5;
        n_pal_r[0] = r_b1_ra;
        n_pal_r[1] = r_b1_rb;
        n_pal_g[0] = r_b1_ga;
        n_pal_g[1] = r_b1_gb;
        for (int i = 0; i < 6; i++) begin
            pr7 = {13'd0, r_b1_rnum7[i]} * {11'd0, bc5nm_pkg::RECIP_7};
            pg7 = {13'd0, r_b1_gnum7[i]} * {11'd0, bc5nm_pkg::RECIP_7};
            if (i < 4) begin
                pr5 = {12'd0, r_b1_rnum5[i]} * {10'd0, bc5nm_pkg::RECIP_5};
                pg5 = {12'd0, r_b1_gnum5[i]} * {10'd0, bc5nm_pkg::RECIP_5};
            end else begin
                pr5 = (i == 4) ? 23'd0 : 23'(255) << bc5nm_pkg::RECIP_SHIFT;
                pg5 = pr5;
            end
            n_pal_r[i+2] = r_b1_rmode7 ? pr7[bc5nm_pkg::RECIP_SHIFT +: CW]
                                       : pr5[bc5nm_pkg::RECIP_SHIFT +: CW];
            n_pal_g[i+2] = r_b1_gmode7 ? pg7[bc5nm_pkg::RECIP_SHIFT +: CW]
                                       : pg5[bc5nm_pkg::RECIP_SHIFT +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (b2_take) begin
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b2_take && r_b1_valid) begin
            r_pal_r   <= n_pal_r;
            r_pal_g   <= n_pal_g;
            r_b2_ridx <= r_b1_ridx;
            r_b2_gidx <= r_b1_gidx;
        end
    end

    // Texel issue: one texel per advancing cycle while a block is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign sel_r         = r_b2_ridx[bc5nm_pkg::IDX_W*r_cnt +: bc5nm_pkg::IDX_W];
    assign sel_g         = r_b2_gidx[bc5nm_pkg::IDX_W*r_cnt +: bc5nm_pkg::IDX_W];
    assign n_t1_tag.num  = r_cnt;
    assign n_t1_tag.last = (r_cnt == bc5nm_pkg::LAST_TEXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else if (en) begin
            r_t1_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_red   <= r_pal_r[sel_r];
            r_t1_green <= r_pal_g[sel_g];
            r_t1_tag   <= n_t1_tag;
        end
    end

    bc5nm_zrec u_zrec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_t1_valid),
        .i_red   (r_t1_red),
        .i_green (r_t1_green),
        .i_tag   (r_t1_tag),
        .o_valid (z_valid),
        .o_red   (z_red),
        .o_green (z_green),
        .o_blue  (z_blue),
        .o_tag   (z_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= z_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_red   <= z_red;
            r_out_green <= z_green;
            r_out_blue  <= z_blue;
            r_out_tag   <= z_tag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_tag.last;
    assign m_axis_tdata  = {4'd0, bc5nm_pkg::ALPHA_FULL, r_out_blue, r_out_green,
                            r_out_red, r_out_tag.num};

    a_cnt_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_b2_valid)
        else $error("Texel counter is mid-block without a held block.");

    a_block_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && (r_cnt == bc5nm_pkg::LAST_TEXEL) && !r_b1_valid) |=> !r_b2_valid)
        else $error("Block was not released after its last texel.");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_tag.last == (r_out_tag.num == bc5nm_pkg::LAST_TEXEL)))
        else $error("End-of-block flag disagrees with the texel number.");

endmodule

>>> test/tb_bc5_normal_map_block_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench that streams BC5 blocks into the decoder and checks every texel it returns.
module tb_bc5_normal_map_block_decoder_unit;

    localparam int unsigned TEXELS = bc5nm_pkg::TEXELS;
    localparam int unsigned CNT_W  = bc5nm_pkg::CNT_W;
    localparam int unsigned CH_W   = bc5nm_pkg::CH_W;
    localparam int unsigned IDX_W  = bc5nm_pkg::IDX_W;

    typedef struct packed {
        logic [CNT_W-1:0] num;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             last;
    } t_texel;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // Fields from bit 0: red_endpoint_a, red_endpoint_b, red_indices,
    // green_endpoint_a, green_endpoint_b, green_indices.
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // Fields from bit 0: texel_number, red, green, blue, alpha, then zero padding.
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;

    logic [127:0] blocks_waiting[$];
    t_texel       texels_due[$];
    int           blocks_queued = 0;
    int           blocks_accepted = 0;
    logic         block_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           holds_served = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           errors = 0;

    bc5_normal_map_block_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [CH_W-1:0] palette_entry(input logic [CH_W-1:0] e0,
                                                      input logic [CH_W-1:0] e1,
                                                      input logic [IDX_W-1:0] k);
        int unsigned a;
        int unsigned b;
        int unsigned i;
        a = e0;
        b = e1;
        i = k;
        if (i == 0) return e0;
        if (i == 1) return e1;
        if (a > b) return CH_W'(((8 - i) * a + (i - 1) * b) / 7);
        if (i < 6) return CH_W'(((6 - i) * a + (i - 1) * b) / 5);
        return (i == 6) ? 8'd0 : 8'd255;
    endfunction

    function automatic logic [CH_W-1:0] normal_z(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g);
        int u;
        int v;
        int s;
        int root;
        u = 2 * int'(r) - 255;
        v = 2 * int'(g) - 255;
        s = 65025 - u * u - v * v;
        if (s <= 0) return bc5nm_pkg::BLUE_FLAT;
        root = 0;
        while ((root + 1) * (root + 1) <= s) root++;
        return CH_W'((root + 255) / 2);
    endfunction

    task automatic decode_block(input logic [127:0] blk);
        t_texel tx;
        int     t;
        for (t = 0; t < TEXELS; t++) begin
            tx.num   = CNT_W'(t);
            tx.red   = palette_entry(blk[7:0], blk[15:8], blk[16 + 3 * t +: 3]);
            tx.green = palette_entry(blk[71:64], blk[79:72], blk[80 + 3 * t +: 3]);
            tx.blue  = normal_z(tx.red, tx.green);
            tx.alpha = bc5nm_pkg::ALPHA_FULL;
            tx.last  = (tx.num == bc5nm_pkg::LAST_TEXEL);
            texels_due.push_back(tx);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic queue_block(input logic [7:0] ra, input logic [7:0] rb, input logic [47:0] ri,
                               input logic [7:0] ga, input logic [7:0] gb, input logic [47:0] gi);
        blocks_waiting.push_back({gi, gb, ga, ri, rb, ra});
        blocks_queued++;
    endtask

    function automatic logic [47:0] index_ramp(input int offset);
        logic [47:0] idx;
        int          t;
        for (t = 0; t < TEXELS; t++) idx[3 * t +: 3] = 3'((t + offset) % 8);
        return idx;
    endfunction

    function automatic logic [7:0] random_endpoint();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        logic [7:0]  ra;
        logic [7:0]  rb;
        logic [7:0]  ga;
        logic [7:0]  gb;
        logic [63:0] ri;
        logic [63:0] gi;
        repeat (count) begin
            ra = random_endpoint();
            rb = ($urandom_range(7) == 0) ? ra : random_endpoint();
            ga = random_endpoint();
            gb = ($urandom_range(7) == 0) ? ga : random_endpoint();
            ri = {$urandom, $urandom};
            gi = {$urandom, $urandom};
            queue_block(ra, rb, ri[47:0], ga, gb, gi[47:0]);
        end
    endtask

    task automatic wait_accepted();
        while (blocks_accepted != blocks_queued) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (blocks_accepted != blocks_queued || texels_due.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || block_taken) begin
            if (blocks_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata  <= blocks_waiting.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served  <= holds_served + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : texel_monitor
        t_texel got;
        t_texel want;
        block_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            decode_block(s_axis_tdata);
            blocks_accepted++;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got.num   = m_axis_tdata[3:0];
            got.red   = m_axis_tdata[11:4];
            got.green = m_axis_tdata[19:12];
            got.blue  = m_axis_tdata[27:20];
            got.alpha = m_axis_tdata[35:28];
            got.last  = m_axis_tlast;
            if (texels_due.size() == 0) begin
                $display("%0t: texel %0d arrived with none expected", $time, got.num);
                errors++;
            end else begin
                want = texels_due.pop_front();
                check_field("texel_number", 8'(want.num), 8'(got.num));
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha", want.alpha, got.alpha);
                check_field("last_texel", 8'(want.last), 8'(got.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_bc5_normal_map_block_decoder_unit: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed blocks: extremes, both palette modes, equal endpoints and the disc edge.
        queue_block(8'd0, 8'd0, 48'h0, 8'd0, 8'd0, 48'h0);
        queue_block(8'd255, 8'd255, '1, 8'd255, 8'd255, '1);
        queue_block(8'd200, 8'd10, index_ramp(0), 8'd250, 8'd3, index_ramp(3));
        queue_block(8'd10, 8'd200, index_ramp(0), 8'd3, 8'd250, index_ramp(5));
        queue_block(8'd128, 8'd128, index_ramp(1), 8'd127, 8'd127, index_ramp(2));
        queue_block(8'd255, 8'd0, index_ramp(0), 8'd0, 8'd255, index_ramp(4));
        queue_block(8'd0, 8'd255, index_ramp(6), 8'd255, 8'd0, index_ramp(7));
        queue_block(8'd127, 8'd128, 48'h0, 8'd128, 8'd127, 48'h0);
        queue_block(8'd255, 8'd0, 48'h0, 8'd128, 8'd0, 48'h0);
        queue_block(8'd255, 8'd0, 48'h0, 8'd127, 8'd0, 48'h0);
        queue_block(8'd0, 8'd1, 48'h0, 8'd1, 8'd0, 48'h249249249249);
        queue_block(8'd1, 8'd0, index_ramp(2), 8'd0, 8'd1, index_ramp(6));
        queue_block(8'd90, 8'd160, 48'hAAAAAAAAAAAA, 8'd170, 8'd60, 48'h555555555555);
        queue_block(8'd30, 8'd220, 48'h924924924924, 8'd220, 8'd30, 48'h924924924924);
        queue_block(8'd40, 8'd80, 48'hDB6DB6DB6DB6, 8'd80, 8'd40, 48'hFFFFFFFFFFFF);
        queue_block(8'd5, 8'd250, 48'hFFFFFFFFFFFF, 8'd240, 8'd240, 48'hDB6DB6DB6DB6);
        queue_block(8'd64, 8'd192, 48'h555555555555, 8'd192, 8'd64, 48'hAAAAAAAAAAAA);
        queue_block(8'd128, 8'd127, index_ramp(0), 8'd128, 8'd127, index_ramp(1));
        wait_accepted();

        queue_random(60);
        wait_accepted();

        send_idle_pct  = 83;
        recv_stall_pct = 0;
        queue_random(70);
        wait_accepted();

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        queue_random(70);
        wait_drained();

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        queue_random(70);
        wait_accepted();

        // The receiver holds off for a long stretch while requests keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        queue_random(40);
        wait_drained();

        queue_random(42);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && texels_due.size() == 0) begin
            $display("tb_bc5_normal_map_block_decoder_unit: clean");
        end else begin
            $display("tb_bc5_normal_map_block_decoder_unit: errors");
        end
        $finish;
    end

endmodule
